// ----- sv/touchpad_tap_drag_gesture_core_defines.svh -----
// Assertion macros for the touchpad tap and drag gesture core.
`ifndef TOUCHPAD_TAP_DRAG_GESTURE_CORE_DEFINES_SVH
`define TOUCHPAD_TAP_DRAG_GESTURE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check on every clock edge outside reset.
`define TDG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every clock edge, reset included.
`define TDG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define TDG_ASSERT(lbl, prop, msg)
`define TDG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- sv/tdg_pkg.sv -----
// Shared types and constants for the touchpad tap and drag gesture core.
package tdg_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TAP_TIME    = 3'd0,
    CFG_REARM_TIME  = 3'd1,
    CFG_LOCK_ON     = 3'd2,
    CFG_LOCK_LIMIT  = 3'd3,
    CFG_GRACE_LIMIT = 3'd4,
    CFG_TAP_MOVE    = 3'd5,
    CFG_SAME_SPOT   = 3'd6,
    CFG_HOLD_MS     = 3'd7
  } cfg_idx_e;

  localparam logic [15:0] TapTimeRst    = 16'd180;
  localparam logic [15:0] RearmTimeRst  = 16'd300;
  localparam logic        LockOnRst     = 1'b0;
  localparam logic [15:0] LockLimitRst  = 16'd500;
  localparam logic [15:0] GraceLimitRst = 16'd100;
  localparam logic [15:0] TapMoveRst    = 16'd50;
  localparam logic [15:0] SameSpotRst   = 16'd200;
  localparam logic [15:0] HoldMsRst     = 16'd30;

  // Phase codes as seen on the result stream
  localparam logic [2:0] PHASE_IDLE   = 3'd0;
  localparam logic [2:0] PHASE_TOUCH  = 3'd1;
  localparam logic [2:0] PHASE_TAPPED = 3'd2;
  localparam logic [2:0] PHASE_REDOWN = 3'd3;
  localparam logic [2:0] PHASE_DRAG   = 3'd4;
  localparam logic [2:0] PHASE_WAIT   = 3'd5;
  localparam logic [2:0] PHASE_DEAD   = 3'd6;

  // Contact event of one report against the previous one
  typedef enum logic [1:0] {
    EVT_DOWN = 2'd0,
    EVT_UP   = 2'd1,
    EVT_MOVE = 2'd2,
    EVT_AWAY = 2'd3
  } ev_e;

  typedef struct packed {
    ev_e         ev;
    logic [15:0] x;
    logic [15:0] y;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [15:0] tap_time_limit;
    logic [15:0] rearm_time_limit;
    logic        drag_lock_on;
    logic [15:0] drag_lock_limit;
    logic [15:0] drop_grace_limit;
    logic [15:0] tap_move_limit;
    logic [15:0] same_spot_limit;
    logic [15:0] release_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- sv/touchpad_tap_drag_gesture_core.sv -----
// Top level of the touchpad tap, double tap and tap-and-drag gesture core.
//
//  Channel  Direction  Handshake                       Payload
//  s_axis   in         s_axis_tvalid_i/s_axis_tready_o touch report (72-bit tdata)
//  m_axis   out        m_axis_tvalid_o/m_axis_tready_i gesture result (8-bit tdata)
//  cfg      in         cfg_we_i                        cfg_idx_i, cfg_data_i
//
// One report per cycle sustained while the event queue has room. A report is
// classified in the cycle it is accepted, passes through the event queue and
// the result register, and is then valid on m_axis. The front end stalls only
// when the event queue is full; the phase machine stalls only when the result
// register is held by m_axis. Reset clears phase, debounce state, the queue and
// loads register defaults.
`include "touchpad_tap_drag_gesture_core_defines.svh"
module touchpad_tap_drag_gesture_core
  import tdg_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Touch reports
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [71:0]         s_axis_tdata_i,  // touch_present, pos_x, pos_y, time_ms, zero pad
  // Gesture results
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [7:0]          m_axis_tdata_o   // button_held, double_tap, gesture_phase, zero pad
);

  cfg_t    cfg_q;
  q_stat_t q_stat;
  logic    push, pop;
  item_t   push_item, head_item;

  // Result fields as seen on m_axis, for the checks below
  logic       res_held, res_dtap;
  logic [2:0] res_phase;
  logic       held_phase_ok;

  // Configuration registers; bits above a register's width are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_time_limit   <= TapTimeRst;
      cfg_q.rearm_time_limit <= RearmTimeRst;
      cfg_q.drag_lock_on     <= LockOnRst;
      cfg_q.drag_lock_limit  <= LockLimitRst;
      cfg_q.drop_grace_limit <= GraceLimitRst;
      cfg_q.tap_move_limit   <= TapMoveRst;
      cfg_q.same_spot_limit  <= SameSpotRst;
      cfg_q.release_hold_ms  <= HoldMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TAP_TIME:    cfg_q.tap_time_limit   <= cfg_data_i;
        CFG_REARM_TIME:  cfg_q.rearm_time_limit <= cfg_data_i;
        CFG_LOCK_ON:     cfg_q.drag_lock_on     <= cfg_data_i[0];
        CFG_LOCK_LIMIT:  cfg_q.drag_lock_limit  <= cfg_data_i;
        CFG_GRACE_LIMIT: cfg_q.drop_grace_limit <= cfg_data_i;
        CFG_TAP_MOVE:    cfg_q.tap_move_limit   <= cfg_data_i;
        CFG_SAME_SPOT:   cfg_q.same_spot_limit  <= cfg_data_i;
        CFG_HOLD_MS:     cfg_q.release_hold_ms  <= cfg_data_i;
        default:         cfg_q.release_hold_ms  <= cfg_q.release_hold_ms;
      endcase
    end
  end

  // Debounce and classify each report as it is accepted
  tdg_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid_i),
    .in_ready_o        (s_axis_tready_o),
    .touch_present_i   (s_axis_tdata_i[0]),
    .pos_x_i           (s_axis_tdata_i[16:1]),
    .pos_y_i           (s_axis_tdata_i[32:17]),
    .time_ms_i         (s_axis_tdata_i[64:33]),
    .release_hold_ms_i (cfg_q.release_hold_ms),
    .q_stat_i          (q_stat),
    .push_o            (push),
    .push_item_o       (push_item)
  );

  // Decouple classification from the phase machine
  tdg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .stat_o      (q_stat)
  );

  // Advance the gesture phase and register one result per event
  tdg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .head_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  assign res_held      = m_axis_tdata_o[0];
  assign res_dtap      = m_axis_tdata_o[1];
  assign res_phase     = m_axis_tdata_o[4:2];
  assign held_phase_ok = (res_phase == PHASE_TAPPED) || (res_phase == PHASE_REDOWN) ||
                         (res_phase == PHASE_DRAG) || (res_phase == PHASE_WAIT);

  // A double tap always ends in idle with the button released
  `TDG_ASSERT(a_dtap_idle, m_axis_tvalid_o && res_dtap |-> !res_held && (res_phase == PHASE_IDLE), "double tap without release to idle")
  // The button is only held in the tapped, redown, drag and wait phases
  `TDG_ASSERT(a_held_phase, m_axis_tvalid_o && res_held |-> held_phase_ok, "button held in wrong phase")
  // With nothing queued or pending, a report's result appears once it has passed the queue and the result register
  `TDG_ASSERT(a_latency, s_axis_tvalid_i && s_axis_tready_o && q_stat.empty && !m_axis_tvalid_o |=> ##1 m_axis_tvalid_o, "result of an unobstructed report is late")
  // No result leaves while or right after reset is held
  `TDG_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid_o, "result valid out of reset")

endmodule

// ----- sv/tdg_front.sv -----
// Front end: debounces contact loss and classifies each report into an event.
module tdg_front
  import tdg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        touch_present_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [31:0] time_ms_i,
  input  logic [15:0] release_hold_ms_i,
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output item_t       push_item_o
);

  logic        loss_valid_q, loss_valid_d;
  logic [31:0] loss_time_q, loss_time_d;
  logic        prev_contact_q, prev_contact_d;
  logic [31:0] loss_ref;
  logic [31:0] since_loss;
  logic        contact;

  assign in_ready_o = !q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // First absent report starts the loss timer
  assign loss_ref   = loss_valid_q ? loss_time_q : time_ms_i;
  assign since_loss = time_ms_i - loss_ref;
  assign contact    = touch_present_i || (since_loss < 32'(release_hold_ms_i));

  always_comb begin
    loss_valid_d   = loss_valid_q;
    loss_time_d    = loss_time_q;
    prev_contact_d = prev_contact_q;
    if (push_o) begin
      loss_valid_d   = !touch_present_i;
      loss_time_d    = touch_present_i ? loss_time_q : loss_ref;
      prev_contact_d = contact;
    end
  end

  always_comb begin
    push_item_o.x   = pos_x_i;
    push_item_o.y   = pos_y_i;
    push_item_o.now = time_ms_i;
    priority if (contact && !prev_contact_q) begin
      push_item_o.ev = EVT_DOWN;
    end else if (!contact && prev_contact_q) begin
      push_item_o.ev = EVT_UP;
    end else if (contact) begin
      push_item_o.ev = EVT_MOVE;
    end else begin
      push_item_o.ev = EVT_AWAY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loss_valid_q   <= 1'b0;
      loss_time_q    <= '0;
      prev_contact_q <= 1'b0;
    end else begin
      loss_valid_q   <= loss_valid_d;
      loss_time_q    <= loss_time_d;
      prev_contact_q <= prev_contact_d;
    end
  end

endmodule

// ----- sv/tdg_queue.sv -----
// Small register queue of classified events between front and back end.
module tdg_queue
  import tdg_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   push_item_i,
  input  logic    pop_i,
  output item_t   head_o,
  output q_stat_t stat_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- sv/tdg_back.sv -----
// Back end: gesture phase machine with a registered result stage.
module tdg_back
  import tdg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  q_stat_t    q_stat_i,
  input  item_t      head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_data_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = PHASE_IDLE,
    PH_TOUCH  = PHASE_TOUCH,
    PH_TAPPED = PHASE_TAPPED,
    PH_REDOWN = PHASE_REDOWN,
    PH_DRAG   = PHASE_DRAG,
    PH_WAIT   = PHASE_WAIT,
    PH_DEAD   = PHASE_DEAD
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] anchor_time_q, anchor_time_d;
  logic [15:0] anchor_x_q, anchor_x_d;
  logic [15:0] anchor_y_q, anchor_y_d;
  logic [15:0] wait_limit_q, wait_limit_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_data_q, out_data_d;

  logic [31:0] dt;
  logic [15:0] dx, dy, near_lim, lift_wait;
  logic        near, dt_tap_ok, dt_rearm_ok, dt_wait_ok;
  logic        held, dtap;

  assign pop_o       = !q_stat_i.empty && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign dt          = head_i.now - anchor_time_q;
  assign dx          = (head_i.x > anchor_x_q) ? head_i.x - anchor_x_q
                                               : anchor_x_q - head_i.x;
  assign dy          = (head_i.y > anchor_y_q) ? head_i.y - anchor_y_q
                                               : anchor_y_q - head_i.y;
  // Second touch after a tap is checked against the wider same-spot window
  assign near_lim    = (phase_q == PH_TAPPED) ? cfg_i.same_spot_limit : cfg_i.tap_move_limit;
  assign near        = (dx <= near_lim) && (dy <= near_lim);
  assign dt_tap_ok   = dt <= 32'(cfg_i.tap_time_limit);
  assign dt_rearm_ok = dt <= 32'(cfg_i.rearm_time_limit);
  assign dt_wait_ok  = dt <= 32'(wait_limit_q);
  assign lift_wait   = cfg_i.drag_lock_on ? cfg_i.drag_lock_limit : cfg_i.drop_grace_limit;

  always_comb begin
    phase_d       = phase_q;
    anchor_time_d = anchor_time_q;
    anchor_x_d    = anchor_x_q;
    anchor_y_d    = anchor_y_q;
    wait_limit_d  = wait_limit_q;
    held          = 1'b0;
    dtap          = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (head_i.ev == EVT_DOWN) begin
          phase_d = PH_TOUCH;
        end
      end
      PH_TOUCH: begin
        if (head_i.ev == EVT_UP) begin
          if (dt_tap_ok && near) begin
            phase_d = PH_TAPPED;
            held    = 1'b1;
          end else begin
            phase_d = PH_IDLE;
          end
        end else if (head_i.ev == EVT_MOVE) begin
          if (!near) phase_d = PH_DEAD;
        end else if (head_i.ev == EVT_AWAY) begin
          if (!dt_tap_ok) phase_d = PH_DEAD;
        end
      end
      PH_TAPPED: begin
        held = 1'b1;
        if (head_i.ev == EVT_DOWN) begin
          if (dt_rearm_ok && near) begin
            phase_d = PH_REDOWN;
          end else begin
            phase_d = PH_IDLE;
            held    = 1'b0;
          end
        end else if (head_i.ev == EVT_AWAY && !dt_rearm_ok) begin
          phase_d = PH_IDLE;
          held    = 1'b0;
        end
      end
      PH_REDOWN: begin
        held = 1'b1;
        if (head_i.ev == EVT_UP) begin
          dtap    = dt_tap_ok && near;
          phase_d = PH_IDLE;
          held    = 1'b0;
        end else if (head_i.ev == EVT_MOVE) begin
          phase_d = PH_DRAG;
        end else if (head_i.ev == EVT_AWAY && !dt_tap_ok) begin
          phase_d = PH_IDLE;
          held    = 1'b0;
        end
      end
      PH_DRAG: begin
        held = 1'b1;
        if (head_i.ev == EVT_UP) begin
          anchor_time_d = head_i.now;
          wait_limit_d  = lift_wait;
          if (lift_wait != '0) begin
            phase_d = PH_WAIT;
          end else begin
            phase_d = PH_IDLE;
            held    = 1'b0;
          end
        end
      end
      PH_WAIT: begin
        held = 1'b1;
        if (head_i.ev == EVT_DOWN) begin
          if (dt_wait_ok) begin
            phase_d = PH_DRAG;
          end else begin
            phase_d = PH_IDLE;
            held    = 1'b0;
          end
        end else if (head_i.ev == EVT_AWAY && !dt_wait_ok) begin
          phase_d = PH_IDLE;
          held    = 1'b0;
        end
      end
      PH_DEAD: begin
        if (head_i.ev == EVT_UP) phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
    // Anchor moves on touch start, tap and re-down
    if ((phase_q == PH_IDLE && phase_d == PH_TOUCH) ||
        (phase_q == PH_TOUCH && phase_d == PH_TAPPED) ||
        (phase_q == PH_TAPPED && phase_d == PH_REDOWN)) begin
      anchor_time_d = head_i.now;
      anchor_x_d    = head_i.x;
      anchor_y_d    = head_i.y;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
      out_data_d  = {3'b000, phase_d, dtap, held};
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      anchor_time_q <= '0;
      anchor_x_q    <= '0;
      anchor_y_q    <= '0;
      wait_limit_q  <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
    end else begin
      if (pop_o) begin
        phase_q       <= phase_d;
        anchor_time_q <= anchor_time_d;
        anchor_x_q    <= anchor_x_d;
        anchor_y_q    <= anchor_y_d;
        wait_limit_q  <= wait_limit_d;
      end
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

endmodule
